>>> design/bht_pkg.sv
package bht_pkg;

   localparam int BUCKETS_DEF = 1024;
   localparam int WAYS_DEF    = 4;

   // Bucket index comes from the high key word times the bucket count
   localparam int KEY_HI_W    = 32;
   localparam int MAX_IDX_W   = 20;

   localparam int QUEUE_DEPTH = 2;

   // depth - 3*age + 2 spans -765 .. 257
   localparam int SCORE_W     = 11;

   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 64;

   localparam logic [1:0] CMD_PROBE = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] BOUND_EXACT = 2'd3;

   localparam logic signed [SCORE_W-1:0] EXACT_BONUS = 11'sd2;

   typedef struct packed {
      logic [15:0]        tag;
      logic [15:0]        move;
      logic signed [15:0] eval;
      logic signed [15:0] value;
      logic [7:0]         depth;
      logic [1:0]         bound;
      logic [7:0]         age;
   } entry_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [MAX_IDX_W-1:0] bucket;
      logic [15:0]          tag;
      logic [1:0]           way;
      logic [15:0]          move;
      logic signed [15:0]   eval;
      logic signed [15:0]   value;
      logic [7:0]           depth;
      logic [1:0]           bound;
   } item_type;

endpackage

>>> design/bht_front.sv
module bht_front #(
   parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
   parameter int WAYS    = bht_pkg::WAYS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [1:0]                      req_tuser,   // command
   // key, target_way, best_move, static_eval, search_value, search_depth,
   // bound_kind, zero pad
   input  logic [bht_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            sweeping,
   output logic                            push_valid,
   output bht_pkg::item_type               push_item,
   input  logic                            push_ready
);

   localparam int PROD_W = bht_pkg::KEY_HI_W + bht_pkg::MAX_IDX_W + 1;

   logic [PROD_W-1:0]  product;
   logic               way_ok;
   logic               keep;
   logic               accept;
   bht_pkg::item_type  fresh;
   bht_pkg::item_type  stage_ff, stage_in;
   logic               stage_valid_ff, stage_valid_in;

   assign product = PROD_W'(req_tdata[63:32]) * PROD_W'(BUCKETS);
   assign way_ok  = {2'b00, req_tdata[65:64]} < 4'(WAYS);

   always_comb begin
      unique case (req_tuser) inside
         bht_pkg::CMD_PROBE, bht_pkg::CMD_CLEAR: keep = 1'b1;
         bht_pkg::CMD_WRITE:                     keep = way_ok;
         default:                                keep = 1'b0;
      endcase
   end

   always_comb begin
      fresh.cmd    = req_tuser;
      fresh.bucket = product[bht_pkg::KEY_HI_W +: bht_pkg::MAX_IDX_W];
      fresh.tag    = req_tdata[15:0];
      fresh.way    = req_tdata[65:64];
      fresh.move   = req_tdata[81:66];
      fresh.eval   = req_tdata[97:82];
      fresh.value  = req_tdata[113:98];
      fresh.depth  = req_tdata[121:114];
      fresh.bound  = req_tdata[123:122];
   end

   assign req_tready = !sweeping && (!stage_valid_ff || push_ready);
   assign accept     = req_tvalid && req_tready;
   assign push_valid = stage_valid_ff;
   assign push_item  = stage_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      if (accept) begin
         // drop unused commands and writes past the last way
         stage_valid_in = keep;
         stage_in       = fresh;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

>>> design/bht_queue.sv
module bht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  bht_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output bht_pkg::item_type pop_item,
   input  logic              pop_ready
);

   localparam int QD     = bht_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNT_W  = $clog2(QD + 1);

   bht_pkg::item_type  slots_ff [QD];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = count_ff != CNT_W'(QD);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   // hold a refused transaction unchanged until the queue takes it
   a_push_held: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid && $stable(push_item))
      else $error("waiting transaction changed before the queue took it");
`endif

endmodule

>>> design/bht_back.sv
module bht_back #(
   parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
   parameter int WAYS    = bht_pkg::WAYS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [7:0]                      csr_wdata,
   input  logic                            pop_valid,
   input  bht_pkg::item_type               pop_item,
   output logic                            pop_ready,
   output logic                            sweeping,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_tuser,
   output logic [bht_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SCORE_W = bht_pkg::SCORE_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_PICK  = 2'd3;

   typedef bht_pkg::entry_type [WAYS-1:0] row_type;

   row_type                    mem [BUCKETS];
   row_type                    row_ff;
   row_type                    wr_row;
   row_type                    merged;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic                       rd_en;

   logic [1:0]                 state_ff, state_in;
   bht_pkg::item_type          cur_ff, cur_in;
   logic [7:0]                 gen_ff, gen_in;
   logic [IDX_W-1:0]           clr_cnt_ff, clr_cnt_in;

   logic [WAYS-1:0]            hit_vec_now, hit_vec_ff, hit_vec_in;
   logic [WAYS-1:0]            empty_vec_now, empty_vec_ff, empty_vec_in;
   logic signed [SCORE_W-1:0]  score_now [WAYS];
   logic signed [SCORE_W-1:0]  score_ff [WAYS];
   logic signed [SCORE_W-1:0]  score_in [WAYS];
   logic signed [SCORE_W-1:0]  score_best;

   logic [WAY_W-1:0]           hit_way, empty_way, min_way, pick_way;
   logic                       hit_any, empty_any;
   bht_pkg::entry_type         sel;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_tuser_ff, rsp_tuser_in;
   logic [bht_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign pop_ready  = state_ff == ST_IDLE;
   assign sweeping   = state_ff == ST_CLEAR;
   assign rd_en      = pop_ready && pop_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         row_ff <= mem[pop_item.bucket[IDX_W-1:0]];
      end
   end

   // Tag compare and replacement score for every way of the bucket
   always_comb begin
      logic [7:0] age;
      age = '0;
      for (int w = 0; w < WAYS; w++) begin
         age = gen_ff - row_ff[w].age;
         hit_vec_now[w]   = row_ff[w].tag == cur_ff.tag;
         empty_vec_now[w] = row_ff[w].tag == '0;
         // depth - 3*age, plus the bonus for an exact bound
         score_now[w] = $signed({3'b000, row_ff[w].depth})
                      - $signed({2'b00, age, 1'b0})
                      - $signed({3'b000, age})
                      + ((row_ff[w].bound == bht_pkg::BOUND_EXACT)
                         ? bht_pkg::EXACT_BONUS : '0);
      end
   end

   // Read-modify-write of the target way
   always_comb begin
      logic differs;
      logic deeper;
      differs = 1'b0;
      deeper  = 1'b0;
      merged  = row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (4'(w) == {2'b00, cur_ff.way}) begin
            differs = row_ff[w].tag != cur_ff.tag;
            deeper  = (cur_ff.depth > row_ff[w].depth)
                   || (cur_ff.bound == bht_pkg::BOUND_EXACT
                       && cur_ff.depth >= row_ff[w].depth);
            merged[w].age = gen_ff;
            if (cur_ff.move != '0 || differs) begin
               merged[w].move = cur_ff.move;
            end
            if (deeper || differs) begin
               merged[w].tag   = cur_ff.tag;
               merged[w].eval  = cur_ff.eval;
               merged[w].value = cur_ff.value;
               merged[w].depth = cur_ff.depth;
               merged[w].bound = cur_ff.bound;
            end
         end
      end
   end

   // First hit, else first empty, else lowest score with the lowest way on ties
   always_comb begin
      hit_way    = '0;
      empty_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec_ff[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_vec_ff[w]) begin
            empty_way = WAY_W'(w);
         end
      end
      score_best = score_ff[0];
      min_way    = '0;
      for (int w = 1; w < WAYS; w++) begin
         if (score_ff[w] < score_best) begin
            score_best = score_ff[w];
            min_way    = WAY_W'(w);
         end
      end
      hit_any   = |hit_vec_ff;
      empty_any = |empty_vec_ff;
      pick_way  = hit_any ? hit_way : (empty_any ? empty_way : min_way);
      sel       = row_ff[hit_way];
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      gen_in       = gen_ff;
      clr_cnt_in   = clr_cnt_ff;
      hit_vec_in   = hit_vec_ff;
      empty_vec_in = empty_vec_ff;
      score_in     = score_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tuser_in = rsp_tuser_ff;
      rsp_tdata_in = rsp_tdata_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_cnt_ff;
      wr_row       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_cnt_ff == IDX_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               cur_in = pop_item;
               if (pop_item.cmd == bht_pkg::CMD_CLEAR) begin
                  gen_in     = '0;
                  clr_cnt_in = '0;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (cur_ff.cmd == bht_pkg::CMD_WRITE) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff.bucket[IDX_W-1:0];
               wr_row   = merged;
               state_in = ST_IDLE;
            end else begin
               hit_vec_in   = hit_vec_now;
               empty_vec_in = empty_vec_now;
               score_in     = score_now;
               state_in     = ST_PICK;
            end
         end
         ST_PICK: begin
            // hold the decision until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tuser_in = hit_any;
               rsp_tdata_in = {4'b0000, 2'(pick_way),
                               hit_any ? {sel.bound, sel.depth, sel.value,
                                          sel.eval, sel.move} : 58'b0};
               state_in     = ST_IDLE;
            end
         end
      endcase

      if (csr_wen) begin
         gen_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      hit_vec_ff   <= hit_vec_in;
      empty_vec_ff <= empty_vec_in;
      score_ff     <= score_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

`ifndef ASSERT_OFF
   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop_ready)
      else $error("queue popped during clearing pass");

   a_rsp_from_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PICK) && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result loaded outside pick state");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_CLEAR
             || (state_ff == ST_LOOK && cur_ff.cmd == bht_pkg::CMD_WRITE))
      else $error("store written outside clear or write");

   a_pick_follows_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK && !$past(state_ff == ST_PICK) |-> $past(state_ff == ST_LOOK))
      else $error("pick entered without a lookup");
`endif

endmodule

>>> design/bucketed_hash_table_with_replacement_core.sv
// Channel   Dir  Handshake                  Payload
// req       in   req_tvalid / req_tready    tuser: command; tdata: key .. bound_kind
// rsp       out  rsp_tvalid / rsp_tready    tuser: hit; tdata: found_move .. chosen_way
// csr       in   csr_wen                    csr_wdata: search_generation
//
// A probe passes the lookup engine as read, compare/score and pick; a write as read
// and write back; both are bound by the single-port bucket memory.
// The front register and a queue slot each hold the item; the bucket read issues
// in the cycle the engine takes the item from the queue.
// Reset starts a clearing pass over all BUCKETS buckets with req_tready low; a clear
// command runs the same pass and zeroes the generation.
// A stalled result waits in the output register while the queue keeps filling.
module bucketed_hash_table_with_replacement_core #(
   parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
   parameter int WAYS    = bht_pkg::WAYS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [1:0]                      req_tuser,   // command
   // key, target_way, best_move, static_eval, search_value, search_depth,
   // bound_kind, zero pad
   input  logic [bht_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_tuser,   // hit
   // found_move, found_eval, found_value, found_depth, found_bound,
   // chosen_way, zero pad
   output logic [bht_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [7:0]                      csr_wdata
);

   logic              sweeping;
   logic              push_valid;
   logic              push_ready;
   bht_pkg::item_type push_item;
   logic              pop_valid;
   logic              pop_ready;
   bht_pkg::item_type pop_item;

   bht_front #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .sweeping   (sweeping),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   bht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   bht_back #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .sweeping   (sweeping),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
